@@ rtl/assert_macros.svh @@
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication at every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that the consequent holds in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ rtl/sbt_pkg.sv @@
//------------------------------------------------------------------------------
// sbt_pkg
// Shared types, token kinds and scan modes of the source byte tokenizer.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sbt_pkg;
	localparam int POS_W   = 16;
	localparam int LINE_W  = 16;
	localparam int KW_MAX  = 6;
	localparam int KIND_W  = 6;
	localparam int MODE_W  = 4;
	localparam int MAX_RES = 4;
	localparam int CNT_W   = 3;

	localparam logic [MODE_W-1:0] M_IDLE     = 4'd0;
	localparam logic [MODE_W-1:0] M_IDENT    = 4'd1;
	localparam logic [MODE_W-1:0] M_NUMBER   = 4'd2;
	localparam logic [MODE_W-1:0] M_NUMDOT   = 4'd3;
	localparam logic [MODE_W-1:0] M_FRACTION = 4'd4;
	localparam logic [MODE_W-1:0] M_OP       = 4'd5;
	localparam logic [MODE_W-1:0] M_COMMENT  = 4'd6;
	localparam logic [MODE_W-1:0] M_STRING   = 4'd7;
	localparam logic [MODE_W-1:0] M_STRESC   = 4'd8;
	localparam logic [MODE_W-1:0] M_CHOPEN   = 4'd9;
	localparam logic [MODE_W-1:0] M_CHESC    = 4'd10;
	localparam logic [MODE_W-1:0] M_CHCLOSE  = 4'd11;
	localparam logic [MODE_W-1:0] M_CHSKIP   = 4'd12;

	localparam logic [KIND_W-1:0] K_INT     = 6'd0;
	localparam logic [KIND_W-1:0] K_FLOAT   = 6'd1;
	localparam logic [KIND_W-1:0] K_STRING  = 6'd2;
	localparam logic [KIND_W-1:0] K_CHAR    = 6'd3;
	localparam logic [KIND_W-1:0] K_IDENT   = 6'd4;
	localparam logic [KIND_W-1:0] K_RETURN  = 6'd5;
	localparam logic [KIND_W-1:0] K_BUFFER  = 6'd6;
	localparam logic [KIND_W-1:0] K_KWCHAR  = 6'd7;
	localparam logic [KIND_W-1:0] K_KWINT   = 6'd8;
	localparam logic [KIND_W-1:0] K_INT64   = 6'd9;
	localparam logic [KIND_W-1:0] K_KWFLOAT = 6'd10;
	localparam logic [KIND_W-1:0] K_BOOL    = 6'd11;
	localparam logic [KIND_W-1:0] K_KWSTR   = 6'd12;
	localparam logic [KIND_W-1:0] K_IF      = 6'd13;
	localparam logic [KIND_W-1:0] K_ELSIF   = 6'd14;
	localparam logic [KIND_W-1:0] K_ELSE    = 6'd15;
	localparam logic [KIND_W-1:0] K_WHILE   = 6'd16;
	localparam logic [KIND_W-1:0] K_TRUE    = 6'd18;
	localparam logic [KIND_W-1:0] K_FALSE   = 6'd19;
	localparam logic [KIND_W-1:0] K_COMMA   = 6'd20;
	localparam logic [KIND_W-1:0] K_SEMI    = 6'd35;
	localparam logic [KIND_W-1:0] K_LPAREN  = 6'd31;
	localparam logic [KIND_W-1:0] K_RPAREN  = 6'd32;
	localparam logic [KIND_W-1:0] K_LBRACE  = 6'd33;
	localparam logic [KIND_W-1:0] K_RBRACE  = 6'd34;
	localparam logic [KIND_W-1:0] K_EOF     = 6'd36;
	localparam logic [KIND_W-1:0] K_INVALID = 6'd37;
	localparam logic [KIND_W-1:0] K_LBRACK  = 6'd38;
	localparam logic [KIND_W-1:0] K_RBRACK  = 6'd39;
	localparam logic [KIND_W-1:0] K_DOT     = 6'd44;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  start;
		logic [POS_W-1:0]  len;
		logic [LINE_W-1:0] line;
		logic [LINE_W-1:0] col;
		logic              err;
		logic              src_err;
		logic              last;
	} tok_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		tok_t [MAX_RES-1:0] tok;
	} tok_group_t;

	function automatic logic [KIND_W-1:0] op_kind(input logic [7:0] c, input logic twice);
		logic [KIND_W-1:0] k;
		case (c)
			8'h2B:   k = twice ? 6'd22 : 6'd21;
			8'h2D:   k = twice ? 6'd24 : 6'd23;
			8'h2A:   k = twice ? 6'd26 : 6'd25;
			8'h2F:   k = twice ? 6'd28 : 6'd27;
			8'h3D:   k = twice ? 6'd30 : 6'd29;
			8'h3E:   k = twice ? 6'd42 : 6'd40;
			default: k = twice ? 6'd43 : 6'd41;
		endcase
		return k;
	endfunction

	// Compare the stored identifier prefix against the keyword list.
	function automatic logic [KIND_W-1:0] kw_kind(input logic [8*KW_MAX-1:0] p,
			input logic [POS_W-1:0] n);
		logic [KIND_W-1:0] k;
		k = K_IDENT;
		case (n)
			16'd2: if (p[15:0] == 16'h6669) k = K_IF;
			16'd3: if (p[23:0] == 24'h746E69) k = K_KWINT;
			16'd4: begin
				if (p[31:0] == 32'h72616863) k = K_KWCHAR;
				else if (p[31:0] == 32'h6C6F6F62) k = K_BOOL;
				else if (p[31:0] == 32'h65736C65) k = K_ELSE;
				else if (p[31:0] == 32'h65757274) k = K_TRUE;
			end
			16'd5: begin
				if (p[39:0] == 40'h74616F6C66) k = K_KWFLOAT;
				else if (p[39:0] == 40'h3436746E69) k = K_INT64;
				else if (p[39:0] == 40'h6669736C65) k = K_ELSIF;
				else if (p[39:0] == 40'h656C696877) k = K_WHILE;
				else if (p[39:0] == 40'h65736C6166) k = K_FALSE;
			end
			16'd6: begin
				if (p[47:0] == 48'h726566667562) k = K_BUFFER;
				else if (p[47:0] == 48'h676E69727473) k = K_KWSTR;
				else if (p[47:0] == 48'h6E7275746572) k = K_RETURN;
			end
			default: k = K_IDENT;
		endcase
		return k;
	endfunction
endpackage
`default_nettype wire

@@ rtl/sbt_scan.sv @@
//------------------------------------------------------------------------------
// sbt_scan
// Scanner state and next-state logic; produces up to three tokens per request.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sbt_scan import sbt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic       cmd,
	input  wire logic [7:0] byte_value,
	output tok_group_t      grp
);
	localparam logic [POS_W-1:0]  PMAX = '1;
	localparam logic [LINE_W-1:0] LMAX = '1;

	logic [MODE_W-1:0] mode_q, mode_d;
	logic [7:0]        pend_q, pend_d;
	logic [POS_W-1:0]  coff_q, coff_d, tstart_q, tstart_d, cb0_q, cb0_d, len_q, len_d;
	logic [LINE_W-1:0] cline_q, cline_d, ccol_q, ccol_d, tline_q, tline_d;
	logic [LINE_W-1:0] tcol_q, tcol_d, cb1_q, cb1_d;
	logic [8*KW_MAX-1:0] kwp_q, kwp_d;
	logic [1:0]        ef_q, ef_d;

	tok_group_t g;
	logic [7:0] b;
	logic alpha, digit, ws, goodesc, idle_go;
	logic [POS_W-1:0] off_inc, len_inc;

	function automatic logic [POS_W-1:0] pinc(input logic [POS_W-1:0] v);
		return (v == PMAX) ? v : v + 1'b1;
	endfunction

	always_comb begin
		b = byte_value;
		alpha = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == 8'h5F;
		digit = b >= 8'h30 && b <= 8'h39;
		ws = b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A;
		goodesc = b == 8'h6E || b == 8'h74 || b == 8'h72 || b == 8'h30 || b == 8'h5C
			|| b == 8'h22 || b == 8'h27;
		off_inc = pinc(coff_q);
		len_inc = pinc(len_q);
	end

	always_comb begin
		mode_d = mode_q; pend_d = pend_q; coff_d = coff_q; cline_d = cline_q;
		ccol_d = ccol_q; tstart_d = tstart_q; tline_d = tline_q; tcol_d = tcol_q;
		cb0_d = cb0_q; cb1_d = cb1_q; kwp_d = kwp_q; ef_d = ef_q; len_d = len_q;
		g = '0;
		idle_go = 1'b0;
		if (cmd) begin
			// Flush the open token, then close the source.
			case (mode_q)
				M_IDENT: begin
					g.tok[g.count] = '{kw_kind(kwp_q, len_q), tstart_q, len_q, tline_q,
						tcol_q, ef_q[0], 1'b0, 1'b0};
					g.count = g.count + 1'b1;
				end
				M_NUMBER, M_FRACTION: begin
					g.tok[g.count] = '{(mode_q == M_NUMBER) ? K_INT : K_FLOAT, tstart_q,
						len_q, tline_q, tcol_q, ef_q[0], 1'b0, 1'b0};
					g.count = g.count + 1'b1;
				end
				M_NUMDOT: begin
					g.tok[0] = '{K_INT, tstart_q, len_q, tline_q, tcol_q, ef_q[0], 1'b0, 1'b0};
					g.tok[1] = '{K_DOT, cb0_q, 16'd1, tline_q, cb1_q, 1'b0, 1'b0, 1'b0};
					g.count = 3'd2;
				end
				M_OP: begin
					g.tok[0] = '{op_kind(pend_q, 1'b0), tstart_q, len_q, tline_q, tcol_q,
						ef_q[0], 1'b0, 1'b0};
					g.count = 3'd1;
				end
				M_STRING, M_STRESC, M_CHOPEN, M_CHESC, M_CHCLOSE: begin
					g.tok[0] = '{K_INVALID, cb0_q, len_q, tline_q, tcol_q, 1'b1, 1'b0, 1'b0};
					g.count = 3'd1;
				end
				default: ;
			endcase
			g.tok[g.count] = '{K_EOF, coff_q, '0, cline_q, ccol_q, 1'b0,
				ef_q[1] | (g.count != 3'd0 && g.tok[0].err) | (g.count == 3'd2 && g.tok[1].err),
				1'b0};
			g.count = g.count + 1'b1;
			mode_d = M_IDLE; pend_d = '0; coff_d = '0; cline_d = 16'd1; ccol_d = 16'd1;
			tstart_d = '0; tline_d = 16'd1; tcol_d = 16'd1; cb0_d = '0; cb1_d = '0;
			kwp_d = '0; ef_d = '0; len_d = '0;
		end else begin
			case (mode_q)
				M_IDENT: begin
					if (alpha || digit) begin
						case (len_q)
							16'd1: kwp_d[15:8] = b;
							16'd2: kwp_d[23:16] = b;
							16'd3: kwp_d[31:24] = b;
							16'd4: kwp_d[39:32] = b;
							16'd5: kwp_d[47:40] = b;
							default: ;
						endcase
						len_d = len_inc;
					end else begin
						g.tok[0] = '{kw_kind(kwp_q, len_q), tstart_q, len_q, tline_q, tcol_q,
							ef_q[0], 1'b0, 1'b0};
						g.count = 3'd1;
						idle_go = 1'b1;
					end
				end
				M_NUMBER: begin
					if (digit) len_d = len_inc;
					else if (b == 8'h2E) begin
						cb0_d = coff_q; cb1_d = ccol_q; mode_d = M_NUMDOT;
					end else begin
						g.tok[0] = '{K_INT, tstart_q, len_q, tline_q, tcol_q, ef_q[0], 1'b0, 1'b0};
						g.count = 3'd1;
						idle_go = 1'b1;
					end
				end
				M_NUMDOT: begin
					if (digit) begin
						len_d = pinc(len_inc); mode_d = M_FRACTION;
					end else begin
						g.tok[0] = '{K_INT, tstart_q, len_q, tline_q, tcol_q, ef_q[0], 1'b0, 1'b0};
						g.tok[1] = '{K_DOT, cb0_q, 16'd1, tline_q, cb1_q, 1'b0, 1'b0, 1'b0};
						g.count = 3'd2;
						idle_go = 1'b1;
					end
				end
				M_FRACTION: begin
					if (digit) len_d = len_inc;
					else begin
						g.tok[0] = '{K_FLOAT, tstart_q, len_q, tline_q, tcol_q, ef_q[0], 1'b0, 1'b0};
						g.count = 3'd1;
						idle_go = 1'b1;
					end
				end
				M_OP: begin
					if (pend_q == 8'h2F && b == 8'h2F) mode_d = M_COMMENT;
					else if (b == 8'h3D) begin
						len_d = 16'd2;
						g.tok[0] = '{op_kind(pend_q, 1'b1), tstart_q, 16'd2, tline_q, tcol_q,
							ef_q[0], 1'b0, 1'b0};
						g.count = 3'd1;
						mode_d = M_IDLE;
					end else begin
						g.tok[0] = '{op_kind(pend_q, 1'b0), tstart_q, len_q, tline_q, tcol_q,
							ef_q[0], 1'b0, 1'b0};
						g.count = 3'd1;
						idle_go = 1'b1;
					end
				end
				M_COMMENT: if (b == 8'h0A) mode_d = M_IDLE;
				M_STRING: begin
					if (b == 8'h22) begin
						g.tok[0] = '{K_STRING, cb0_q, len_q, tline_q, tcol_q, ef_q[0], 1'b0, 1'b0};
						g.count = 3'd1;
						mode_d = M_IDLE;
					end else if (b == 8'h0A) begin
						g.tok[0] = '{K_INVALID, cb0_q, len_q, tline_q, tcol_q, 1'b1, 1'b0, 1'b0};
						g.count = 3'd1;
						idle_go = 1'b1;
					end else begin
						len_d = len_inc;
						if (b == 8'h5C) mode_d = M_STRESC;
					end
				end
				M_STRESC: begin
					if (!goodesc) ef_d[0] = 1'b1;
					len_d = len_inc; mode_d = M_STRING;
				end
				M_CHOPEN: begin
					len_d = 16'd1;
					mode_d = (b == 8'h5C) ? M_CHESC : M_CHCLOSE;
				end
				M_CHESC: begin
					if (!goodesc) ef_d[0] = 1'b1;
					len_d = 16'd2; mode_d = M_CHCLOSE;
				end
				M_CHCLOSE: begin
					g.count = 3'd1;
					if (b == 8'h27) begin
						g.tok[0] = '{K_CHAR, cb0_q, len_q, tline_q, tcol_q, ef_q[0], 1'b0, 1'b0};
						mode_d = M_IDLE;
					end else begin
						g.tok[0] = '{K_INVALID, cb0_q, len_q, tline_q, tcol_q, 1'b1, 1'b0, 1'b0};
						ef_d[0] = 1'b1;
						if (b == 8'h0A) idle_go = 1'b1;
						else mode_d = M_CHSKIP;
					end
				end
				M_CHSKIP: begin
					if (b == 8'h27) mode_d = M_IDLE;
					else if (b == 8'h0A) idle_go = 1'b1;
				end
				default: idle_go = 1'b1;
			endcase
			// Fold emitted token errors into the source flag.
			if ((g.count != 3'd0 && g.tok[0].err) || (g.count == 3'd2 && g.tok[1].err))
				ef_d[1] = 1'b1;
			if (idle_go) begin
				mode_d = M_IDLE;
				if (!ws) begin
					tstart_d = coff_q; tline_d = cline_q; tcol_d = ccol_q;
					len_d = 16'd1; ef_d[0] = 1'b0;
					if (alpha) begin
						kwp_d = {40'd0, b}; mode_d = M_IDENT;
					end else if (digit) mode_d = M_NUMBER;
					else if (b == 8'h22 || b == 8'h27) begin
						len_d = '0; cb0_d = off_inc;
						mode_d = (b == 8'h22) ? M_STRING : M_CHOPEN;
					end else if (b inside {8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D, 8'h3E, 8'h3C}) begin
						pend_d = b; mode_d = M_OP;
					end else begin
						g.tok[g.count] = '{K_INVALID, coff_q, 16'd1, cline_q, ccol_q, 1'b0,
							1'b0, 1'b0};
						case (b)
							8'h2E: g.tok[g.count].kind = K_DOT;
							8'h2C: g.tok[g.count].kind = K_COMMA;
							8'h3B: g.tok[g.count].kind = K_SEMI;
							8'h28: g.tok[g.count].kind = K_LPAREN;
							8'h29: g.tok[g.count].kind = K_RPAREN;
							8'h7B: g.tok[g.count].kind = K_LBRACE;
							8'h7D: g.tok[g.count].kind = K_RBRACE;
							8'h5B: g.tok[g.count].kind = K_LBRACK;
							8'h5D: g.tok[g.count].kind = K_RBRACK;
							default: begin
								g.tok[g.count].err = 1'b1;
								ef_d = 2'b11;
							end
						endcase
						g.count = g.count + 1'b1;
					end
				end
			end
			coff_d = off_inc;
			if (b == 8'h0A) begin
				cline_d = (cline_q == LMAX) ? cline_q : cline_q + 1'b1;
				ccol_d = 16'd1;
			end else ccol_d = (ccol_q == LMAX) ? ccol_q : ccol_q + 1'b1;
		end
		if (g.count != 3'd0) g.tok[g.count - 1'b1].last = 1'b1;
	end

	assign grp = g;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; pend_q <= '0; coff_q <= '0; cline_q <= 16'd1;
			ccol_q <= 16'd1; tstart_q <= '0; tline_q <= 16'd1; tcol_q <= 16'd1;
			cb0_q <= '0; cb1_q <= '0; kwp_q <= '0; ef_q <= '0; len_q <= '0;
		end else if (take) begin
			mode_q <= mode_d; pend_q <= pend_d; coff_q <= coff_d; cline_q <= cline_d;
			ccol_q <= ccol_d; tstart_q <= tstart_d; tline_q <= tline_d; tcol_q <= tcol_d;
			cb0_q <= cb0_d; cb1_q <= cb1_d; kwp_q <= kwp_d; ef_q <= ef_d; len_q <= len_d;
		end
	end
endmodule
`default_nettype wire

@@ rtl/sbt_outq.sv @@
//------------------------------------------------------------------------------
// sbt_outq
// Token queue: a ring of DEPTH tokens that drains one per cycle while stall is low.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sbt_outq import sbt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  tok_group_t grp,
	output logic      room,
	output logic      valid,
	input  wire logic stall,
	output tok_t      head
);
	localparam int DEPTH = 8;
	localparam int AW = 3;
	tok_t mem_q [DEPTH];
	logic [AW-1:0] rd_q, wr_q;
	logic [AW:0]   cnt_q;
	logic pop;

	assign valid = cnt_q != '0;
	assign head  = mem_q[rd_q];
	assign pop   = valid && !stall;
	// Room for a full group of four, even if none drains.
	assign room  = cnt_q <= (AW+1)'(DEPTH - MAX_RES);

	always_ff @(posedge clk) begin
		if (push)
			for (int i = 0; i < MAX_RES; i++)
				if (i < int'(grp.count)) mem_q[wr_q + AW'(i)] <= grp.tok[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0; wr_q <= '0; cnt_q <= '0;
		end else begin
			if (pop) rd_q <= rd_q + 1'b1;
			if (push) wr_q <= wr_q + grp.count;
			cnt_q <= cnt_q + (push ? {1'b0, grp.count} : '0) - {{AW{1'b0}}, pop};
		end
	end
endmodule
`default_nettype wire

@@ rtl/source_byte_tokenizer.sv @@
// Source byte tokenizer.
// Output: a token is written to the queue as its request is accepted.
// Throughput: one request per cycle while the queue holds four tokens or fewer;
// a request yields up to three tokens, which leave one per cycle while out_stall
// is low, from an eight-entry token queue.
// Reset: arst_n clears the scanner to line 1, column 1, and empties the queue.
//------------------------------------------------------------------------------
// source_byte_tokenizer
// Top level: scanner plus token queue with valid/stall handshakes.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module source_byte_tokenizer import sbt_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              cmd,
	input  wire logic [7:0]        byte_value,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [KIND_W-1:0]      token_kind,
	output logic [POS_W-1:0]       start_offset,
	output logic [POS_W-1:0]       token_length,
	output logic [LINE_W-1:0]      line_number,
	output logic [LINE_W-1:0]      column_number,
	output logic                   token_error,
	output logic                   source_had_error,
	output logic                   last_of_run
);
	tok_group_t grp;
	tok_t       head;
	logic       room, take;

	// Stall the source only when the queue could not hold a full group.
	assign in_stall = !room;
	assign take = in_valid && room;

	sbt_scan u_scan (.clk, .arst_n, .take, .cmd, .byte_value, .grp);

	// Push every accepted request; groups with no tokens just pass through.
	sbt_outq u_outq (.clk, .arst_n, .push(take), .grp, .room, .valid(out_valid),
		.stall(out_stall), .head);

	assign token_kind       = head.kind;
	assign start_offset     = head.start;
	assign token_length     = head.len;
	assign line_number      = head.line;
	assign column_number    = head.col;
	assign token_error      = head.err;
	assign source_had_error = head.src_err;
	assign last_of_run      = head.last;
endmodule
`default_nettype wire

@@ rtl/sbt_checker.sv @@
//------------------------------------------------------------------------------
// sbt_checker
// Port-level checks of the tokenizer, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sbt_checker import sbt_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [KIND_W-1:0] token_kind,
	input wire logic [LINE_W-1:0] line_number,
	input wire logic [LINE_W-1:0] column_number,
	input wire logic              source_had_error
);
	`CHK_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(token_kind), "stalled token changed")
	`CHK_IMPLY(a_line, clk, arst_n, out_valid, line_number != '0 && column_number != '0, "zero position")
	`CHK_IMPLY(a_src, clk, arst_n, out_valid && token_kind != K_EOF, !source_had_error, "source error off EOF")
endmodule
bind source_byte_tokenizer sbt_checker u_chk (.clk, .arst_n, .out_valid, .out_stall,
	.token_kind, .line_number, .column_number, .source_had_error);
`default_nettype wire

@@ verif/tb_top.sv @@
//------------------------------------------------------------------------------
// tb_top
// Self-checking bench for the source byte tokenizer: a directed table, then
// random source text, checked token by token against a scanner model in the
// bench.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import sbt_pkg::*;

	// Token kinds that the package does not name
	localparam logic [KIND_W-1:0] TK_PLUS   = 6'd21;
	localparam logic [KIND_W-1:0] TK_PLUSEQ = 6'd22;
	localparam logic [KIND_W-1:0] TK_MINUS  = 6'd23;
	localparam logic [KIND_W-1:0] TK_MINEQ  = 6'd24;
	localparam logic [KIND_W-1:0] TK_STAR   = 6'd25;
	localparam logic [KIND_W-1:0] TK_STAREQ = 6'd26;
	localparam logic [KIND_W-1:0] TK_SLASH  = 6'd27;
	localparam logic [KIND_W-1:0] TK_SLEQ   = 6'd28;
	localparam logic [KIND_W-1:0] TK_ASSIGN = 6'd29;
	localparam logic [KIND_W-1:0] TK_EQEQ   = 6'd30;
	localparam logic [KIND_W-1:0] TK_GT     = 6'd40;
	localparam logic [KIND_W-1:0] TK_LT     = 6'd41;
	localparam logic [KIND_W-1:0] TK_GE     = 6'd42;
	localparam logic [KIND_W-1:0] TK_LE     = 6'd43;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_END  = 1'b1;

	localparam int CYCLE_LIMIT = 2000000;

	// Scanner modes of the bench model
	typedef enum logic [3:0] {
		SC_IDLE, SC_IDENT, SC_NUMBER, SC_NUMDOT, SC_FRACTION, SC_OP, SC_COMMENT,
		SC_STRING, SC_STRESC, SC_CHOPEN, SC_CHESC, SC_CHCLOSE, SC_CHSKIP
	} scan_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cmd = 1'b0;
	logic [7:0] byte_value = 8'd0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [KIND_W-1:0] token_kind;
	logic [POS_W-1:0] start_offset, token_length;
	logic [LINE_W-1:0] line_number, column_number;
	logic token_error, source_had_error, last_of_run;

	always #5 clk = ~clk;

	source_byte_tokenizer u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .byte_value(byte_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.token_kind(token_kind), .start_offset(start_offset), .token_length(token_length),
		.line_number(line_number), .column_number(column_number),
		.token_error(token_error), .source_had_error(source_had_error),
		.last_of_run(last_of_run)
	);

	// Tokens still owed by the block, oldest first
	tok_t pending_tokens[$];
	int mismatches = 0;
	bit quiet = 1'b0;	// no idling on either side while set

	//--------------------------------------------------------------------------
	// Scanner model
	//--------------------------------------------------------------------------
	scan_e sc_mode;
	logic [7:0] sc_pend;
	logic [POS_W-1:0] sc_off, sc_tstart, sc_dot_off, sc_cstart, sc_len, at_off;
	logic [LINE_W-1:0] sc_line, sc_col, sc_tline, sc_tcol, sc_dot_col, at_line, at_col;
	logic [7:0] sc_word[KW_MAX];
	logic sc_tok_err, sc_src_err;
	tok_t step_toks[MAX_RES];
	int step_cnt;

	function automatic logic [15:0] sat_up(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic bit is_letter(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
	endfunction

	function automatic bit is_num(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic bit escape_ok(input logic [7:0] b);
		return b == "n" || b == "t" || b == "r" || b == "0" || b == "\\" || b == "\""
			|| b == "'";
	endfunction

	function automatic logic [KIND_W-1:0] operator_kind(input logic [7:0] c, input bit dbl);
		case (c)
			"+": return dbl ? TK_PLUSEQ : TK_PLUS;
			"-": return dbl ? TK_MINEQ : TK_MINUS;
			"*": return dbl ? TK_STAREQ : TK_STAR;
			"/": return dbl ? TK_SLEQ : TK_SLASH;
			"=": return dbl ? TK_EQEQ : TK_ASSIGN;
			">": return dbl ? TK_GE : TK_GT;
			default: return dbl ? TK_LE : TK_LT;
		endcase
	endfunction

	function automatic logic [KIND_W-1:0] word_kind();
		string w;
		w = "";
		if (sc_len > KW_MAX) return K_IDENT;
		for (int i = 0; i < sc_len; i++) w = {w, string'(sc_word[i])};
		case (w)
			"buffer": return K_BUFFER;
			"char":   return K_KWCHAR;
			"int":    return K_KWINT;
			"float":  return K_KWFLOAT;
			"bool":   return K_BOOL;
			"int64":  return K_INT64;
			"string": return K_KWSTR;
			"if":     return K_IF;
			"elsif":  return K_ELSIF;
			"while":  return K_WHILE;
			"else":   return K_ELSE;
			"return": return K_RETURN;
			"true":   return K_TRUE;
			"false":  return K_FALSE;
			default:  return K_IDENT;
		endcase
	endfunction

	function automatic void scanner_clear();
		sc_mode = SC_IDLE;
		sc_pend = 8'd0;
		sc_off = '0; sc_line = 16'd1; sc_col = 16'd1;
		sc_tstart = '0; sc_tline = 16'd1; sc_tcol = 16'd1;
		sc_dot_off = '0; sc_dot_col = '0; sc_cstart = '0; sc_len = '0;
		for (int i = 0; i < KW_MAX; i++) sc_word[i] = 8'd0;
		sc_tok_err = 1'b0; sc_src_err = 1'b0;
	endfunction

	function automatic void add_token(input logic [KIND_W-1:0] k, input logic [15:0] st,
			input logic [15:0] ln, input logic [15:0] li, input logic [15:0] co,
			input logic e, input logic se);
		if (step_cnt >= MAX_RES) return;
		step_toks[step_cnt] = '{kind: k, start: st, len: ln, line: li, col: co,
			err: e, src_err: se, last: 1'b0};
		if (e) sc_src_err = 1'b1;
		step_cnt++;
	endfunction

	function automatic void lexeme_token(input logic [KIND_W-1:0] k);
		add_token(k, sc_tstart, sc_len, sc_tline, sc_tcol, sc_tok_err, 1'b0);
	endfunction

	function automatic void content_token(input logic [KIND_W-1:0] k);
		add_token(k, sc_cstart, sc_len, sc_tline, sc_tcol, sc_tok_err, 1'b0);
	endfunction

	function automatic void int_then_dot();
		lexeme_token(K_INT);
		add_token(K_DOT, sc_dot_off, 16'd1, sc_tline, sc_dot_col, 1'b0, 1'b0);
	endfunction

	function automatic void start_fresh(input logic [7:0] b);
		logic [KIND_W-1:0] k;
		sc_mode = SC_IDLE;
		if (b == " " || b == "\t" || b == "\r" || b == "\n") return;
		sc_tstart = at_off; sc_tline = at_line; sc_tcol = at_col;
		sc_len = 16'd1; sc_tok_err = 1'b0;
		if (is_letter(b)) begin
			for (int i = 0; i < KW_MAX; i++) sc_word[i] = 8'd0;
			sc_word[0] = b;
			sc_mode = SC_IDENT;
		end else if (is_num(b)) begin
			sc_mode = SC_NUMBER;
		end else if (b == "\"" || b == "'") begin
			sc_len = '0;
			sc_cstart = sat_up(at_off);
			sc_mode = (b == "\"") ? SC_STRING : SC_CHOPEN;
		end else if (b == "+" || b == "-" || b == "*" || b == "/" || b == "=" || b == ">"
				|| b == "<") begin
			sc_pend = b;
			sc_mode = SC_OP;
		end else begin
			case (b)
				".": k = K_DOT;
				",": k = K_COMMA;
				";": k = K_SEMI;
				"(": k = K_LPAREN;
				")": k = K_RPAREN;
				"{": k = K_LBRACE;
				"}": k = K_RBRACE;
				"[": k = K_LBRACK;
				"]": k = K_RBRACK;
				default: begin
					k = K_INVALID;
					sc_tok_err = 1'b1;
				end
			endcase
			lexeme_token(k);
		end
	endfunction

	function automatic void scan_byte(input logic [7:0] b);
		case (sc_mode)
			SC_IDENT:
				if (is_letter(b) || is_num(b)) begin
					if (sc_len < KW_MAX) sc_word[sc_len[2:0]] = b;
					sc_len = sat_up(sc_len);
				end else begin
					lexeme_token(word_kind());
					start_fresh(b);
				end
			SC_NUMBER:
				if (is_num(b)) sc_len = sat_up(sc_len);
				else if (b == ".") begin
					sc_dot_off = at_off; sc_dot_col = at_col;
					sc_mode = SC_NUMDOT;
				end else begin
					lexeme_token(K_INT);
					start_fresh(b);
				end
			SC_NUMDOT:
				if (is_num(b)) begin
					sc_len = sat_up(sat_up(sc_len));
					sc_mode = SC_FRACTION;
				end else begin
					int_then_dot();
					start_fresh(b);
				end
			SC_FRACTION:
				if (is_num(b)) sc_len = sat_up(sc_len);
				else begin
					lexeme_token(K_FLOAT);
					start_fresh(b);
				end
			SC_OP:
				if (sc_pend == "/" && b == "/") sc_mode = SC_COMMENT;
				else if (b == "=") begin
					sc_len = 16'd2;
					lexeme_token(operator_kind(sc_pend, 1'b1));
					sc_mode = SC_IDLE;
				end else begin
					lexeme_token(operator_kind(sc_pend, 1'b0));
					start_fresh(b);
				end
			SC_COMMENT:
				if (b == "\n") sc_mode = SC_IDLE;
			SC_STRING:
				if (b == "\"") begin
					content_token(K_STRING);
					sc_mode = SC_IDLE;
				end else if (b == "\n") begin
					sc_tok_err = 1'b1;
					content_token(K_INVALID);
					start_fresh(b);
				end else begin
					sc_len = sat_up(sc_len);
					if (b == "\\") sc_mode = SC_STRESC;
				end
			SC_STRESC: begin
				if (!escape_ok(b)) sc_tok_err = 1'b1;
				sc_len = sat_up(sc_len);
				sc_mode = SC_STRING;
			end
			SC_CHOPEN: begin
				sc_len = 16'd1;
				sc_mode = (b == "\\") ? SC_CHESC : SC_CHCLOSE;
			end
			SC_CHESC: begin
				if (!escape_ok(b)) sc_tok_err = 1'b1;
				sc_len = 16'd2;
				sc_mode = SC_CHCLOSE;
			end
			SC_CHCLOSE:
				if (b == "'") begin
					content_token(K_CHAR);
					sc_mode = SC_IDLE;
				end else begin
					sc_tok_err = 1'b1;
					content_token(K_INVALID);
					if (b == "\n") start_fresh(b);
					else sc_mode = SC_CHSKIP;
				end
			SC_CHSKIP:
				if (b == "'") sc_mode = SC_IDLE;
				else if (b == "\n") start_fresh(b);
			default: start_fresh(b);
		endcase
	endfunction

	// Work out the tokens of one accepted request and queue them
	function automatic void predict_request(input logic c, input logic [7:0] b);
		step_cnt = 0;
		if (c == CMD_END) begin
			case (sc_mode)
				SC_IDENT:    lexeme_token(word_kind());
				SC_NUMBER:   lexeme_token(K_INT);
				SC_NUMDOT:   int_then_dot();
				SC_FRACTION: lexeme_token(K_FLOAT);
				SC_OP:       lexeme_token(operator_kind(sc_pend, 1'b0));
				SC_STRING, SC_STRESC, SC_CHOPEN, SC_CHESC, SC_CHCLOSE: begin
					sc_tok_err = 1'b1;
					content_token(K_INVALID);
				end
				default: ;
			endcase
			add_token(K_EOF, sc_off, 16'd0, sc_line, sc_col, 1'b0, sc_src_err);
			scanner_clear();
		end else begin
			at_off = sc_off; at_line = sc_line; at_col = sc_col;
			scan_byte(b);
			sc_off = sat_up(sc_off);
			if (b == "\n") begin
				sc_line = sat_up(sc_line);
				sc_col = 16'd1;
			end else begin
				sc_col = sat_up(sc_col);
			end
		end
		if (step_cnt > 0) step_toks[step_cnt-1].last = 1'b1;
		for (int i = 0; i < step_cnt; i++) pending_tokens.push_back(step_toks[i]);
	endfunction

	//--------------------------------------------------------------------------
	// Request side
	//--------------------------------------------------------------------------
	task automatic send_request(input logic c, input logic [7:0] b);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		// keep the ignored byte random on end requests
		byte_value <= (c == CMD_END) ? 8'($urandom) : b;
		do @(posedge clk); while (in_stall);
		predict_request(c, b);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_request(CMD_BYTE, s[i]);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_tokens.size() != 0) @(posedge clk);
	endtask

	//--------------------------------------------------------------------------
	// Token side: check and stall
	//--------------------------------------------------------------------------
	int hold_left = 0;
	always @(posedge clk) begin
		tok_t seen, want;
		seen = '{kind: token_kind, start: start_offset, len: token_length,
			line: line_number, col: column_number, err: token_error,
			src_err: source_had_error, last: last_of_run};
		if (arst_n && out_valid && !out_stall) begin
			if (pending_tokens.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected token: kind %0d start %0d len %0d", seen.kind,
						seen.start, seen.len);
			end else begin
				want = pending_tokens.pop_front();
				if (seen !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"token mismatch: exp kind %0d start %0d len %0d line %0d ",
							"col %0d err %0d src %0d last %0d / got %0d %0d %0d %0d %0d %0d ",
							"%0d %0d"}, want.kind, want.start, want.len, want.line,
							want.col, want.err, want.src_err, want.last, seen.kind,
							seen.start, seen.len, seen.line, seen.col, seen.err,
							seen.src_err, seen.last);
				end
			end
			hold_left = quiet ? 0 : $urandom_range(0, 15);
			out_stall <= (hold_left != 0);
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= (hold_left != 0);
		end
	end

	// Cycle limit
	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	//--------------------------------------------------------------------------
	// Directed table: a row may carry the kind, length and error of the
	// first token it should produce
	//--------------------------------------------------------------------------
	typedef struct {
		logic c;
		logic [7:0] b;
		bit known;
		logic [KIND_W-1:0] kind;
		logic [15:0] len;
		logic err;
	} dir_row_t;

	localparam int N_DIR = 25;
	dir_row_t dir_rows[N_DIR] = '{
		'{CMD_BYTE, 8'h80, 1'b1, K_INVALID, 16'd1, 1'b1},	// high byte is unknown
		'{CMD_BYTE, 8'h00, 1'b1, K_INVALID, 16'd1, 1'b1},
		'{CMD_BYTE, 8'hFF, 1'b1, K_INVALID, 16'd1, 1'b1},
		'{CMD_BYTE, "i", 1'b0, K_IDENT, 16'd0, 1'b0},
		'{CMD_BYTE, "f", 1'b0, K_IDENT, 16'd0, 1'b0},
		'{CMD_BYTE, " ", 1'b1, K_IF, 16'd2, 1'b0},
		'{CMD_BYTE, "1", 1'b0, K_IDENT, 16'd0, 1'b0},
		'{CMD_BYTE, ".", 1'b0, K_IDENT, 16'd0, 1'b0},
		'{CMD_BYTE, ";", 1'b1, K_INT, 16'd1, 1'b0},	// dot without digit splits off
		'{CMD_BYTE, ">", 1'b0, K_IDENT, 16'd0, 1'b0},
		'{CMD_BYTE, "=", 1'b1, TK_GE, 16'd2, 1'b0},
		'{CMD_BYTE, "/", 1'b0, K_IDENT, 16'd0, 1'b0},
		'{CMD_BYTE, "/", 1'b0, K_IDENT, 16'd0, 1'b0},
		'{CMD_BYTE, "x", 1'b0, K_IDENT, 16'd0, 1'b0},
		'{CMD_BYTE, "\n", 1'b0, K_IDENT, 16'd0, 1'b0},
		'{CMD_BYTE, "\"", 1'b0, K_IDENT, 16'd0, 1'b0},
		'{CMD_BYTE, "\\", 1'b0, K_IDENT, 16'd0, 1'b0},
		'{CMD_BYTE, "q", 1'b0, K_IDENT, 16'd0, 1'b0},	// bad escape
		'{CMD_BYTE, "\"", 1'b1, K_STRING, 16'd2, 1'b1},
		'{CMD_BYTE, "'", 1'b0, K_IDENT, 16'd0, 1'b0},
		'{CMD_BYTE, "a", 1'b0, K_IDENT, 16'd0, 1'b0},
		'{CMD_BYTE, "b", 1'b1, K_INVALID, 16'd1, 1'b1},	// char literal not closed
		'{CMD_BYTE, "'", 1'b0, K_IDENT, 16'd0, 1'b0},
		'{CMD_BYTE, "\"", 1'b0, K_IDENT, 16'd0, 1'b0},
		'{CMD_END, 8'h00, 1'b1, K_INVALID, 16'd0, 1'b1}	// end inside a string
	};

	string snippets[] = '{
		"buffer ", "char ", "int ", "int64 ", "float ", "bool ", "string ", "if(",
		"elsif ", "else{", "while ", "return;", "true,", "false]", "x_9 ", "Abcdefgh ",
		"intx ", "42 ", "3.14;", "7.", "0..1", ".5", "\"hi\\n\"", "\"a\\zb\"", "\"open\n",
		"'c'", "'\\t'", "'\\q'", "'ab'", "'xy\n", "+ ", "+=", "-=", "- ", "*=", "*",
		"/=", "/ ", "==", "= ", "<=", "<", ">", "// note\n", "\t\r\n", "[", "}", "\"\\",
		"'\\", "'"
	};

	initial begin
		int sent;
		tok_t got;
		scanner_clear();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (dir_rows[i]) begin
			send_request(dir_rows[i].c, dir_rows[i].b);
			if (dir_rows[i].known) begin
				// first token of this row sits just behind the ones owed before it
				if (step_cnt > 0)
					got = pending_tokens[pending_tokens.size() - step_cnt];
				else
					got = '0;
				if (step_cnt == 0 || got.kind !== dir_rows[i].kind
						|| got.len !== dir_rows[i].len || got.err !== dir_rows[i].err) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"table row %0d: exp kind %0d len %0d err %0d / ",
							"got kind %0d len %0d err %0d"}, i, dir_rows[i].kind,
							dir_rows[i].len, dir_rows[i].err, got.kind, got.len, got.err);
				end
			end
		end

		// Random source text, mostly well formed
		sent = 0;
		while (sent < 310) begin
			int pick;
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_request(CMD_BYTE, 8'($urandom));
				sent++;
			end else if (pick < 12) begin
				send_request(CMD_END, 8'd0);
				sent++;
			end else begin
				string s;
				s = snippets[$urandom_range(0, snippets.size() - 1)];
				send_text(s);
				sent += s.len();
			end
			if (sent > 150 && sent < 160) begin
				// hold off until every owed token has come
				drain();
				quiet = ~quiet;
				sent = 160;
			end
		end
		send_request(CMD_END, 8'd0);
		quiet = 1'b0;

		// End inside an open string, then a short clean source
		drain();
		send_text("x \"s");
		send_request(CMD_END, 8'd0);
		send_text("ok 1.5");
		send_request(CMD_END, 8'd0);

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_tokens.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/sbt_pkg.sv
rtl/sbt_scan.sv
rtl/sbt_outq.sv
rtl/source_byte_tokenizer.sv
rtl/sbt_checker.sv
verif/tb_top.sv
